@@ rtl/urm_pkg.sv @@
// Shared types and constants for the ultrasonic range measure block.
// No dependencies; imported by rtl/ultrasonic_range_measure.sv.
package urm_pkg;

   // Timer ticks per microsecond and width of the echo tick counter.
   localparam int unsigned TICKS_PER_US = 60;
   localparam int unsigned COUNT_WIDTH  = 24;

   // cm = floor(ticks * CM_SCALE / CM_DIVISOR)
   localparam int unsigned CM_SCALE   = 127;
   localparam int unsigned CM_DIVISOR = TICKS_PER_US * 7400;
   localparam int unsigned REM_WIDTH  = $clog2(CM_DIVISOR + CM_SCALE + 1);

   localparam int unsigned DIST_WIDTH  = 8;
   localparam int unsigned PHASE_WIDTH = 16;

   // Configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIGGER_LOW  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIGGER_HIGH = 1'b1;

   typedef struct packed {
      logic start_req;
      logic sensor_select;
      logic echo_left;
      logic echo_right;
   } req_payload_type;

   typedef struct packed {
      logic                  trigger_left;
      logic                  trigger_right;
      logic                  busy_res;
      logic                  done_res;
      logic [DIST_WIDTH-1:0] distance_cm;
      logic                  measured_sensor;
   } rsp_payload_type;

endpackage

@@ rtl/ultrasonic_range_measure.sv @@
// Top level of the two-sensor ultrasonic range measure block.
// Depends on rtl/urm_pkg.sv for payload types and constants.
//
// Each request beat is one timer tick and produces exactly one response beat
// showing the trigger pins, busy, and (on the completing tick) done with the
// distance in centimeters and the sensor it belongs to. A start taken while
// idle latches the sensor select, holds that trigger low for trigger_low_ticks,
// high for trigger_high_ticks (zero counts as one), then waits for the echo to
// rise and times the high echo. On the tick the echo is low again, done is
// reported with floor(ticks*127/(TICKS_PER_US*7400)) saturated at 255. There is
// no timeout; starts while busy are ignored. Throughput is one beat per cycle
// while the consumer does not stall: the phase sequencer and the distance
// tracker update between the request side and a single response register.
// The distance is kept as a running quotient and remainder that advance by
// 127 per echo tick, so no divider is needed at the end. The request side is
// stalled only while the response register is full and the consumer stalls.
// Configuration registers should be written only while no measurement runs.

module ultrasonic_range_measure
   import urm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // Sequencer phase codes; unused codes act as idle.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LOW  = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_WAIT = 3'd3;
   localparam logic [2:0] PH_MEAS = 3'd4;

   // Configuration
   logic [CSR_DATA_WIDTH-1:0] trigger_low_ticks_ff;
   logic [CSR_DATA_WIDTH-1:0] trigger_high_ticks_ff;

   // Measurement state
   logic [2:0]             phase_ff,         phase_in;
   logic [PHASE_WIDTH-1:0] phase_count_ff,   phase_count_in;
   logic [COUNT_WIDTH-1:0] echo_ticks_ff,    echo_ticks_in;
   logic                   chosen_sensor_ff, chosen_sensor_in;
   logic [DIST_WIDTH-1:0]  cm_ff,            cm_in;
   logic [REM_WIDTH-1:0]   rem_ff,           rem_in;

   // Response register
   logic                   rsp_valid_ff,     rsp_valid_in;
   rsp_payload_type        rsp_data_ff,      rsp_data_in;

   logic                   req_accept;
   logic                   echo;
   logic [PHASE_WIDTH-1:0] high_len;
   logic [REM_WIDTH-1:0]   rem_sum;
   logic                   trig;
   logic                   done;

   // Free a slot whenever the held beat leaves this cycle.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign echo     = chosen_sensor_ff ? req_data.echo_right : req_data.echo_left;
   assign high_len = (trigger_high_ticks_ff == '0) ? PHASE_WIDTH'(1) : trigger_high_ticks_ff;
   assign rem_sum  = rem_ff + REM_WIDTH'(CM_SCALE);

   // Phase sequencer and running distance
   always_comb begin
      phase_in         = phase_ff;
      phase_count_in   = phase_count_ff;
      echo_ticks_in    = echo_ticks_ff;
      chosen_sensor_in = chosen_sensor_ff;
      cm_in            = cm_ff;
      rem_in           = rem_ff;
      done             = 1'b0;

      unique case (phase_ff)
         PH_LOW: begin
            if (phase_count_ff >= trigger_low_ticks_ff) begin
               phase_in       = PH_HIGH;
               phase_count_in = PHASE_WIDTH'(1);
            end else begin
               phase_count_in = phase_count_ff + PHASE_WIDTH'(1);
            end
         end
         PH_HIGH: begin
            if (phase_count_ff >= high_len) begin
               phase_in       = PH_WAIT;
               phase_count_in = '0;
            end else begin
               phase_count_in = phase_count_ff + PHASE_WIDTH'(1);
            end
         end
         PH_WAIT: begin
            if (echo) begin
               phase_in      = PH_MEAS;
               echo_ticks_in = COUNT_WIDTH'(1);
               cm_in         = '0;
               rem_in        = REM_WIDTH'(CM_SCALE);
            end
         end
         PH_MEAS: begin
            if (echo) begin
               // Saturated counter stops the distance too.
               if (echo_ticks_ff != '1) begin
                  echo_ticks_in = echo_ticks_ff + COUNT_WIDTH'(1);
                  if (rem_sum >= REM_WIDTH'(CM_DIVISOR)) begin
                     rem_in = rem_sum - REM_WIDTH'(CM_DIVISOR);
                     if (cm_ff != '1) begin
                        cm_in = cm_ff + DIST_WIDTH'(1);
                     end
                  end else begin
                     rem_in = rem_sum;
                  end
               end
            end else begin
               done           = 1'b1;
               phase_in       = PH_IDLE;
               phase_count_in = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_data.start_req) begin
               chosen_sensor_in = req_data.sensor_select;
               echo_ticks_in    = '0;
               phase_in         = (trigger_low_ticks_ff == '0) ? PH_HIGH : PH_LOW;
               phase_count_in   = PHASE_WIDTH'(1);
            end
         end
      endcase
   end

   // Response beat reflects the state after this tick.
   always_comb begin
      trig                        = (phase_in == PH_HIGH);
      rsp_data_in.trigger_left    = ~chosen_sensor_in & trig;
      rsp_data_in.trigger_right   = chosen_sensor_in & trig;
      rsp_data_in.busy_res        = (phase_in != PH_IDLE);
      rsp_data_in.done_res        = done;
      rsp_data_in.distance_cm     = done ? cm_ff : '0;
      rsp_data_in.measured_sensor = done & chosen_sensor_in;
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_low_ticks_ff  <= CSR_DATA_WIDTH'(120);
         trigger_high_ticks_ff <= CSR_DATA_WIDTH'(600);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRIGGER_LOW:  trigger_low_ticks_ff  <= csr_data;
            CSR_TRIGGER_HIGH: trigger_high_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         phase_count_ff   <= '0;
         echo_ticks_ff    <= '0;
         chosen_sensor_ff <= 1'b0;
         cm_ff            <= '0;
         rem_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff         <= phase_in;
            phase_count_ff   <= phase_count_in;
            echo_ticks_ff    <= echo_ticks_in;
            chosen_sensor_ff <= chosen_sensor_in;
            cm_ff            <= cm_in;
            rem_ff           <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
